// File: rtl/swfbrp_pkg.sv
package swfbrp_pkg;

  localparam int VAL_W      = 31;
  localparam int LEN_W      = 5;
  localparam int TOT_W      = 8;
  localparam int SLOT_W     = 4;
  localparam int NBYTE_W    = 5;
  localparam int Q_AW       = 1;
  localparam int Q_DEPTH    = 1 << Q_AW;
  localparam int RAW_MAX    = 16;
  localparam int EDGE_MAX_W = 17;

  localparam logic [2:0] CMD_RECT   = 3'd0;
  localparam logic [2:0] CMD_MATRIX = 3'd1;
  localparam logic [2:0] CMD_EDGE   = 3'd2;
  localparam logic [2:0] CMD_RAW    = 3'd3;
  localparam logic [2:0] CMD_ALIGN  = 3'd4;

  typedef logic [LEN_W-1:0] len_t;

  // one classified item, widths already resolved
  typedef struct packed {
    logic [2:0]              cmd;
    logic                    err;
    logic                    a_zero;
    logic                    b_zero;
    len_t                    w0;
    len_t                    w1;
    len_t                    w2;
    logic [TOT_W-1:0]        total;
    logic [5:0][VAL_W-1:0]   v;
  } entry_t;

  typedef enum logic [1:0] {
    SK_FIELD,
    SK_FLUSH,
    SK_ERR,
    SK_END
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t        kind;
    len_t              len;
    logic [VAL_W-1:0]  val;
  } slot_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage

// File: rtl/swfbrp_in_if.sv
interface swfbrp_in_if;
  import swfbrp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [2:0]              command;
  logic signed [VAL_W-1:0] value_a;
  logic signed [VAL_W-1:0] value_b;
  logic signed [VAL_W-1:0] value_c;
  logic signed [VAL_W-1:0] value_d;
  logic signed [VAL_W-1:0] value_e;
  logic signed [VAL_W-1:0] value_f;
  logic [LEN_W-1:0]        raw_count;

  modport source (
    output valid, command, value_a, value_b, value_c, value_d, value_e, value_f,
           raw_count,
    input  ready
  );

  modport sink (
    input  valid, command, value_a, value_b, value_c, value_d, value_e, value_f,
           raw_count,
    output ready
  );
endinterface

// File: rtl/swfbrp_out_if.sv
interface swfbrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       range_error;

  modport source (
    output valid, out_byte, last, range_error,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last, range_error,
    output ready
  );
endinterface

// File: rtl/swf_bit_record_packer.sv
// path: an item passes the stage-one registers, the queue and the current-item register
//   before its first byte is offered from the output register
// throughput: the packer emits at most one byte and finishes at most one field per cycle,
//   and only while the output register is empty or being taken; a two-entry queue keeps
//   the input side taking words while the back end works
// reset: synchronous active-low rst_n empties the queue and clears the pending bits
module swf_bit_record_packer (
  input  logic          clk,
  input  logic          rst_n,
  swfbrp_in_if.sink     in_ch,
  swfbrp_out_if.source  out_ch
);
  import swfbrp_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  entry_t  q_push_entry;
  entry_t  q_head;

  swfbrp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_push_entry)
  );

  swfbrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  swfbrp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/swfbrp_front.sv
module swfbrp_front (
  input  logic                clk,
  input  logic                rst_n,
  swfbrp_in_if.sink           in_ch,
  input  logic                q_full,
  output logic                q_push,
  output swfbrp_pkg::entry_t  q_entry
);
  import swfbrp_pkg::*;

  function automatic logic [VAL_W-1:0] sat_val(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v == {1'b1, {(VAL_W-1){1'b0}}}) begin
      r = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};
    end else begin
      r = v;
    end
    return r;
  endfunction

  // bit length of the magnitude plus one, zero for a zero value
  function automatic len_t field_len(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] m;
    len_t             n;
    m = v[VAL_W-1] ? (~v + 1'b1) : v;
    n = '0;
    for (int i = 0; i < VAL_W-1; i++) begin
      if (m[i]) begin
        n = len_t'(i + 2);
      end
    end
    return n;
  endfunction

  function automatic len_t len_max(input len_t a, input len_t b);
    return (a > b) ? a : b;
  endfunction

  logic                  in_fire;
  logic                  cmd_known;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [2:0]            s1_cmd_r;
  logic [5:0][VAL_W-1:0] s1_v_r, s1_v_nxt;
  len_t [5:0]            s1_len_r, s1_len_nxt;
  len_t                  s1_raw_r, s1_raw_nxt;

  len_t                  rect_n;
  len_t                  mat_n1, mat_n2, mat_n3;
  len_t                  edge_n;
  logic [6:0]            mat_sum;
  logic                  edge_az, edge_bz;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cmd_known = (in_ch.command <= CMD_ALIGN);
  assign q_push    = s1_valid_r && !q_full;
  assign in_ch.ready = !s1_valid_r || !q_full;

  // stage one: saturate and measure each value (a raw word stores value_a unsaturated)
  always_comb begin
    s1_v_nxt[0] = (in_ch.command == CMD_RAW) ? in_ch.value_a : sat_val(in_ch.value_a);
    s1_v_nxt[1] = sat_val(in_ch.value_b);
    s1_v_nxt[2] = sat_val(in_ch.value_c);
    s1_v_nxt[3] = sat_val(in_ch.value_d);
    s1_v_nxt[4] = sat_val(in_ch.value_e);
    s1_v_nxt[5] = sat_val(in_ch.value_f);
    s1_len_nxt[0] = field_len(sat_val(in_ch.value_a));
    s1_len_nxt[1] = field_len(s1_v_nxt[1]);
    s1_len_nxt[2] = field_len(s1_v_nxt[2]);
    s1_len_nxt[3] = field_len(s1_v_nxt[3]);
    s1_len_nxt[4] = field_len(s1_v_nxt[4]);
    s1_len_nxt[5] = field_len(s1_v_nxt[5]);
    s1_raw_nxt = (in_ch.raw_count > LEN_W'(RAW_MAX)) ? LEN_W'(RAW_MAX) : in_ch.raw_count;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = cmd_known;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_ch.command;
      s1_v_r   <= s1_v_nxt;
      s1_len_r <= s1_len_nxt;
      s1_raw_r <= s1_raw_nxt;
    end
  end

  // stage two: group widths and record length in bits
  always_comb begin
    rect_n  = len_max(len_max(s1_len_r[0], s1_len_r[1]), len_max(s1_len_r[2], s1_len_r[3]));
    mat_n1  = len_max(LEN_W'(1), len_max(s1_len_r[0], s1_len_r[3]));
    mat_n2  = len_max(LEN_W'(1), len_max(s1_len_r[2], s1_len_r[1]));
    mat_n3  = len_max(LEN_W'(1), len_max(s1_len_r[4], s1_len_r[5]));
    edge_n  = len_max(LEN_W'(2), len_max(s1_len_r[0], s1_len_r[1]));
    edge_az = (s1_len_r[0] == '0);
    edge_bz = (s1_len_r[1] == '0);
    mat_sum = 7'(mat_n1) + 7'(mat_n2) + 7'(mat_n3);

    q_entry        = '0;
    q_entry.cmd    = s1_cmd_r;
    q_entry.v      = s1_v_r;
    q_entry.a_zero = edge_az;
    q_entry.b_zero = edge_bz;
    unique case (s1_cmd_r)
      CMD_RECT: begin
        q_entry.w0    = rect_n;
        q_entry.total = 8'd5 + {1'b0, rect_n, 2'b00};
      end
      CMD_MATRIX: begin
        q_entry.w0    = mat_n1;
        q_entry.w1    = mat_n2;
        q_entry.w2    = mat_n3;
        q_entry.total = 8'd17 + {mat_sum, 1'b0};
      end
      CMD_EDGE: begin
        q_entry.w0  = edge_n;
        q_entry.err = (edge_n > LEN_W'(EDGE_MAX_W));
        if (edge_az || edge_bz) begin
          q_entry.total = 8'd8 + 8'(edge_n);
        end else begin
          q_entry.total = 8'd7 + {2'b00, edge_n, 1'b0};
        end
      end
      CMD_RAW: begin
        q_entry.w0    = s1_raw_r;
        q_entry.total = 8'(s1_raw_r);
      end
      default: begin
        q_entry.total = '0;
      end
    endcase
  end

endmodule

// File: rtl/swfbrp_queue.sv
module swfbrp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  swfbrp_pkg::entry_t  push_entry,
  output logic                full,
  input  logic                pop,
  output swfbrp_pkg::entry_t  head,
  output logic                empty
);
  import swfbrp_pkg::*;

  localparam logic [Q_AW:0] CntFull = (Q_AW+1)'(Q_DEPTH);

  entry_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    count_r, count_nxt;

  assign full  = (count_r == CntFull);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("word pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("word popped from an empty queue");

endmodule

// File: rtl/swfbrp_back.sv
module swfbrp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  swfbrp_pkg::entry_t  q_head,
  input  logic                q_empty,
  output logic                q_pop,
  swfbrp_out_if.source        out_ch
);
  import swfbrp_pkg::*;

  function automatic slot_t slot_of(input entry_t e, input logic [SLOT_W-1:0] s);
    slot_t       r;
    logic [3:0]  n2;
    r.kind = SK_END;
    r.len  = '0;
    r.val  = '0;
    n2     = 4'(e.w0 - LEN_W'(2));
    unique case (e.cmd)
      CMD_RECT: begin
        unique case (s)
          4'd0, 4'd6: r.kind = SK_FLUSH;
          4'd1: begin
            r.kind = SK_FIELD; r.len = LEN_W'(5); r.val = VAL_W'(e.w0);
          end
          4'd2, 4'd3, 4'd4, 4'd5: begin
            r.kind = SK_FIELD; r.len = e.w0; r.val = e.v[3'(s - 4'd2)];
          end
          default: r.kind = SK_END;
        endcase
      end
      CMD_MATRIX: begin
        unique case (s)
          4'd0, 4'd10: r.kind = SK_FLUSH;
          4'd1: begin
            r.kind = SK_FIELD; r.len = LEN_W'(6); r.val = VAL_W'({1'b1, e.w0});
          end
          4'd2: begin r.kind = SK_FIELD; r.len = e.w0; r.val = e.v[0]; end
          4'd3: begin r.kind = SK_FIELD; r.len = e.w0; r.val = e.v[3]; end
          4'd4: begin
            r.kind = SK_FIELD; r.len = LEN_W'(6); r.val = VAL_W'({1'b1, e.w1});
          end
          4'd5: begin r.kind = SK_FIELD; r.len = e.w1; r.val = e.v[2]; end
          4'd6: begin r.kind = SK_FIELD; r.len = e.w1; r.val = e.v[1]; end
          4'd7: begin
            r.kind = SK_FIELD; r.len = LEN_W'(5); r.val = VAL_W'(e.w2);
          end
          4'd8: begin r.kind = SK_FIELD; r.len = e.w2; r.val = e.v[4]; end
          4'd9: begin r.kind = SK_FIELD; r.len = e.w2; r.val = e.v[5]; end
          default: r.kind = SK_END;
        endcase
      end
      CMD_EDGE: begin
        if (e.err) begin
          r.kind = (s == '0) ? SK_ERR : SK_END;
        end else begin
          unique case (s)
            4'd0: begin
              r.kind = SK_FIELD;
              if (e.a_zero) begin
                r.len = LEN_W'(8); r.val = VAL_W'({2'b11, n2, 2'b01});
              end else if (e.b_zero) begin
                r.len = LEN_W'(8); r.val = VAL_W'({2'b11, n2, 2'b00});
              end else begin
                r.len = LEN_W'(7); r.val = VAL_W'({2'b11, n2, 1'b1});
              end
            end
            4'd1: begin
              r.kind = SK_FIELD; r.len = e.w0; r.val = e.a_zero ? e.v[1] : e.v[0];
            end
            4'd2: begin
              r.kind = SK_FIELD;
              r.len  = (e.a_zero || e.b_zero) ? '0 : e.w0;
              r.val  = e.v[1];
            end
            default: r.kind = SK_END;
          endcase
        end
      end
      CMD_RAW: begin
        if (s == '0) begin
          r.kind = SK_FIELD; r.len = e.w0; r.val = e.v[0];
        end
      end
      CMD_ALIGN: begin
        r.kind = (s == '0) ? SK_FLUSH : SK_END;
      end
      default: r.kind = SK_END;
    endcase
    return r;
  endfunction

  bk_state_t              state_r, state_nxt;
  entry_t                 cur_r, cur_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  len_t                   pos_r, pos_nxt;
  logic [6:0]             acc_r, acc_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [NBYTE_W-1:0]     left_r, left_nxt;
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;
  logic                   out_err_r;

  slot_t                  sl;
  logic                   out_free;
  logic                   item_done;
  logic                   load;
  logic                   step;
  logic                   emit;
  logic [7:0]             emit_byte;
  logic                   emit_err;

  len_t                   rem;
  logic [3:0]             room;
  logic [3:0]             k;
  logic [VAL_W-1:0]       shifted;
  logic [8:0]             mask9;
  logic [7:0]             bits8;
  logic [14:0]            acc_sh;
  logic [14:0]            pad_sh;
  logic [7:0]             merged;
  logic [3:0]             fill;
  len_t                   pos_add;
  logic [8:0]             ceil_sum;
  logic [8:0]             stream_sum;
  logic                   pre;

  assign sl        = slot_of(cur_r, slot_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign item_done = (state_r == BK_IDLE) || (sl.kind == SK_END);
  assign load      = item_done && !q_empty;
  assign step      = (state_r == BK_RUN) && (sl.kind != SK_END) && out_free;
  assign q_pop     = load;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (load) state_nxt = BK_RUN;
      BK_RUN:  if (sl.kind == SK_END && !load) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // bit slicing for the current field
  always_comb begin
    rem     = sl.len - pos_r;
    room    = 4'd8 - {1'b0, cnt_r};
    k       = ({1'b0, room} < rem) ? room : rem[3:0];
    shifted = sl.val >> (rem - LEN_W'(k));
    mask9   = (9'd1 << k) - 9'd1;
    bits8   = shifted[7:0] & mask9[7:0];
    acc_sh  = {8'b0, acc_r} << k;
    pad_sh  = {8'b0, acc_r} << room;
    merged  = acc_sh[7:0] | bits8;
    fill    = {1'b0, cnt_r} + k;
    pos_add = pos_r + LEN_W'(k);
  end

  // bytes this item will emit, from the pending count at load time
  always_comb begin
    pre        = (cnt_r != '0);
    ceil_sum   = 9'(q_head.total) + 9'd7;
    stream_sum = 9'(q_head.total) + 9'(cnt_r);
    unique case (q_head.cmd)
      CMD_RECT, CMD_MATRIX: left_nxt = NBYTE_W'(pre) + ceil_sum[7:3];
      CMD_EDGE:             left_nxt = q_head.err ? NBYTE_W'(1) : stream_sum[7:3];
      CMD_RAW:              left_nxt = stream_sum[7:3];
      CMD_ALIGN:            left_nxt = NBYTE_W'(pre);
      default:              left_nxt = '0;
    endcase
  end

  always_comb begin
    cur_nxt   = cur_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    emit_byte = '0;
    emit_err  = 1'b0;
    if (load) begin
      cur_nxt  = q_head;
      slot_nxt = '0;
      pos_nxt  = '0;
    end else if (step) begin
      unique case (sl.kind)
        SK_FIELD: begin
          if (fill == 4'd8) begin
            emit      = 1'b1;
            emit_byte = merged;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            acc_nxt = merged[6:0];
            cnt_nxt = fill[2:0];
          end
          if (pos_add == sl.len) begin
            slot_nxt = slot_r + 1'b1;
            pos_nxt  = '0;
          end else begin
            pos_nxt = pos_add;
          end
        end
        SK_FLUSH: begin
          if (cnt_r != '0) begin
            emit      = 1'b1;
            emit_byte = pad_sh[7:0];
          end
          acc_nxt  = '0;
          cnt_nxt  = '0;
          slot_nxt = slot_r + 1'b1;
        end
        SK_ERR: begin
          emit      = 1'b1;
          emit_err  = 1'b1;
          slot_nxt  = slot_r + 1'b1;
        end
        default: slot_nxt = slot_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      slot_r      <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      if (load) begin
        left_r <= left_nxt;
      end else if (emit) begin
        left_r <= left_r - 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= (left_r == NBYTE_W'(1));
      out_err_r  <= emit_err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.range_error = out_err_r;

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_byte_r == '0 && out_last_r))
    else $error("range error word carries data or is not last");

  a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN && sl.kind == SK_END) |-> (left_r == '0))
    else $error("item finished with bytes still owed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (left_r != '0))
    else $error("byte emitted beyond the item's count");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import swfbrp_pkg::*;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam val_t VAL_POS_MAX  = 31'h3FFF_FFFF;
  localparam val_t VAL_NEG_MAX  = 31'h4000_0001;
  localparam val_t VAL_MOST_NEG = 31'h4000_0000;
  localparam longint MAG_MAX    = 64'h3FFF_FFFF;
  localparam int PHASE_ITEMS    = 100;
  localparam int DRAIN_CYCLES   = 64;

  typedef struct {
    logic [2:0]       cmd;
    val_t             a, b, c, d, e, f;
    logic [LEN_W-1:0] raw_count;
  } in_word_t;

  typedef struct {
    logic [7:0] data;
    logic       lst;
    logic       rng_err;
  } out_word_t;

  class packed_byte_scoreboard;
    out_word_t bytes_due[$];
    logic [6:0] pend_bits;
    int pend_cnt;
    logic [7:0] acc;
    int acc_n;
    int fail_count;
    int bytes_checked;
    int range_errors;
    int cmd_seen[8];

    function new();
      pend_bits = '0;
      pend_cnt = 0;
      fail_count = 0;
      bytes_checked = 0;
      range_errors = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function void emit(logic [7:0] data, logic rng_err);
      out_word_t w;
      w.data = data;
      w.lst = rng_err;
      w.rng_err = rng_err;
      bytes_due.push_back(w);
    endfunction

    function void shift_in_bits(int n, longint unsigned v);
      for (int i = n; i > 0; i--) begin
        acc = {acc[6:0], 1'(v >> (i - 1))};
        acc_n++;
        if (acc_n == 8) begin
          emit(acc, 1'b0);
          acc = '0;
          acc_n = 0;
        end
      end
    endfunction

    function void put_signed(int n, longint v);
      longint unsigned mask;
      mask = (64'd1 << n) - 64'd1;
      shift_in_bits(n, longint'(v) & mask);
    endfunction

    function void flush();
      if (acc_n > 0) begin
        emit(acc << (8 - acc_n), 1'b0);
        acc = '0;
        acc_n = 0;
      end
    endfunction

    function longint sat_value(val_t raw);
      longint s;
      s = raw;
      if (s < -MAG_MAX) s = -MAG_MAX;
      return s;
    endfunction

    function int width_with(int n, longint v);
      longint unsigned m;
      int len;
      if (v == 0) return n;
      m = (v < 0) ? -v : v;
      len = 1;
      while (m != 0) begin
        len++;
        m >>= 1;
      end
      return (len > n) ? len : n;
    endfunction

    function void put_group(longint x, longint y);
      int n;
      n = width_with(width_with(1, x), y);
      shift_in_bits(LEN_W, n);
      put_signed(n, x);
      put_signed(n, y);
    endfunction

    function void note_word(in_word_t w);
      longint a, b, c, d, e, f;
      int n, first, cnt;
      a = sat_value(w.a);
      b = sat_value(w.b);
      c = sat_value(w.c);
      d = sat_value(w.d);
      e = sat_value(w.e);
      f = sat_value(w.f);
      first = bytes_due.size();
      acc = {1'b0, pend_bits};
      acc_n = pend_cnt;
      cmd_seen[w.cmd]++;
      case (w.cmd)
        CMD_RECT: begin
          flush();
          n = width_with(width_with(width_with(width_with(0, a), b), c), d);
          shift_in_bits(LEN_W, n);
          put_signed(n, a);
          put_signed(n, b);
          put_signed(n, c);
          put_signed(n, d);
          flush();
        end
        CMD_MATRIX: begin
          flush();
          shift_in_bits(1, 1);
          put_group(a, d);
          shift_in_bits(1, 1);
          put_group(c, b);
          put_group(e, f);
          flush();
        end
        CMD_EDGE: begin
          n = width_with(width_with(2, a), b);
          if (n > EDGE_MAX_W) begin
            // too wide: one error word, nothing packed
            emit(8'd0, 1'b1);
            return;
          end
          shift_in_bits(2, 3);
          shift_in_bits(4, n - 2);
          if (a == 0) begin
            shift_in_bits(2, 1);
            put_signed(n, b);
          end else if (b == 0) begin
            shift_in_bits(2, 0);
            put_signed(n, a);
          end else begin
            shift_in_bits(1, 1);
            put_signed(n, a);
            put_signed(n, b);
          end
        end
        CMD_RAW: begin
          cnt = (w.raw_count > RAW_MAX) ? RAW_MAX : w.raw_count;
          shift_in_bits(cnt, longint'(w.a) & ((64'd1 << cnt) - 64'd1));
        end
        CMD_ALIGN: flush();
        default: return;
      endcase
      pend_bits = acc[6:0];
      pend_cnt = acc_n;
      if (bytes_due.size() > first) bytes_due[bytes_due.size() - 1].lst = 1'b1;
    endfunction

    function void check_word(logic [7:0] data, logic lst, logic rng_err);
      out_word_t exp_w;
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected word: byte %h last %b range_error %b",
                 $time, data, lst, rng_err);
        fail_count++;
        return;
      end
      exp_w = bytes_due.pop_front();
      bytes_checked++;
      if (rng_err === 1'b1) range_errors++;
      if (data !== exp_w.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, exp_w.data, data);
        fail_count++;
      end
      if (lst !== exp_w.lst) begin
        $display("%0t: last expected %b actual %b", $time, exp_w.lst, lst);
        fail_count++;
      end
      if (rng_err !== exp_w.rng_err) begin
        $display("%0t: range_error expected %b actual %b", $time, exp_w.rng_err, rng_err);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int send_idle_pct;
  int recv_stall_pct;
  packed_byte_scoreboard sb = new();

  swfbrp_in_if  in_ch();
  swfbrp_out_if out_ch();

  swf_bit_record_packer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (rst_n) out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    in_word_t w;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        w.cmd = in_ch.command;
        w.a = in_ch.value_a;
        w.b = in_ch.value_b;
        w.c = in_ch.value_c;
        w.d = in_ch.value_d;
        w.e = in_ch.value_e;
        w.f = in_ch.value_f;
        w.raw_count = in_ch.raw_count;
        sb.note_word(w);
      end
      if (out_ch.valid && out_ch.ready)
        sb.check_word(out_ch.out_byte, out_ch.last, out_ch.range_error);
    end
  end

  function automatic in_word_t mk(logic [2:0] cmd, val_t a, val_t b, val_t c, val_t d,
                                  val_t e, val_t f, logic [LEN_W-1:0] rc);
    in_word_t w;
    w.cmd = cmd;
    w.a = a;
    w.b = b;
    w.c = c;
    w.d = d;
    w.e = e;
    w.f = f;
    w.raw_count = rc;
    return w;
  endfunction

  function automatic val_t rand_value(int max_len);
    int pick, len;
    logic [VAL_W-1:0] mag;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 16) begin
      case ($urandom_range(2))
        0: return VAL_POS_MAX;
        1: return VAL_NEG_MAX;
        default: return VAL_MOST_NEG;
      endcase
    end
    len = $urandom_range(max_len, 1);
    mag = VAL_W'($urandom & ((32'd1 << len) - 32'd1));
    return $urandom_range(1) ? -val_t'(mag) : val_t'(mag);
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int pick, edge_len;
    pick = $urandom_range(99);
    edge_len = ($urandom_range(99) < 85) ? 16 : 30;
    w = mk(CMD_RECT, rand_value(30), rand_value(30), rand_value(30), rand_value(30),
           rand_value(30), rand_value(30), LEN_W'($urandom_range(31)));
    if (pick < 20) w.cmd = CMD_RECT;
    else if (pick < 35) w.cmd = CMD_MATRIX;
    else if (pick < 65) begin
      w.cmd = CMD_EDGE;
      w.a = rand_value(edge_len);
      w.b = rand_value(edge_len);
    end else if (pick < 85) begin
      w.cmd = CMD_RAW;
      if ($urandom_range(99) < 85) w.raw_count = LEN_W'($urandom_range(RAW_MAX, 1));
    end else if (pick < 93) w.cmd = CMD_ALIGN;
    else w.cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = w.cmd;
    in_ch.value_a = w.a;
    in_ch.value_b = w.b;
    in_ch.value_c = w.c;
    in_ch.value_d = w.d;
    in_ch.value_e = w.e;
    in_ch.value_f = w.f;
    in_ch.raw_count = w.raw_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.bytes_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set = '{0, 83, 0, 16};
    stall_set = '{0, 0, 83, 16};
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.value_a = '0;
    in_ch.value_b = '0;
    in_ch.value_c = '0;
    in_ch.value_d = '0;
    in_ch.value_e = '0;
    in_ch.value_f = '0;
    in_ch.raw_count = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed words
    send_word(mk(CMD_RECT, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_RECT, VAL_POS_MAX, VAL_NEG_MAX, VAL_MOST_NEG, 1, 0, 0, 0));
    send_word(mk(CMD_RAW, 31'h5, 0, 0, 0, 0, 0, 3));
    send_word(mk(CMD_RAW, VAL_POS_MAX, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_ALIGN, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_ALIGN, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_RAW, 31'h0000_FFFF, 0, 0, 0, 0, 0, RAW_MAX));
    send_word(mk(CMD_RAW, VAL_MOST_NEG, 0, 0, 0, 0, 0, 5'd31));
    send_word(mk(CMD_RAW, -31'sd1, 0, 0, 0, 0, 0, 5'd17));
    send_word(mk(CMD_RAW, 31'h1, 0, 0, 0, 0, 0, 1));
    send_word(mk(CMD_EDGE, 0, 5, 0, 0, 0, 0, 0));
    send_word(mk(CMD_EDGE, -7, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_EDGE, 3, -100, 0, 0, 0, 0, 0));
    send_word(mk(CMD_EDGE, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_EDGE, 31'sd65535, -31'sd65535, 0, 0, 0, 0, 0));
    send_word(mk(CMD_EDGE, 31'sd65536, 1, 0, 0, 0, 0, 0));
    send_word(mk(CMD_EDGE, 1, VAL_MOST_NEG, 0, 0, 0, 0, 0));
    send_word(mk(CMD_MATRIX, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_MATRIX, VAL_MOST_NEG, VAL_POS_MAX, VAL_NEG_MAX, VAL_POS_MAX,
                 VAL_MOST_NEG, VAL_NEG_MAX, 0));
    send_word(mk(CMD_MATRIX, 1, -1, 2, -2, 0, 9, 0));
    send_word(mk(CMD_RAW, 31'h2, 0, 0, 0, 0, 0, 2));
    send_word(mk(CMD_RSVD_LO, 1, 2, 3, 4, 5, 6, 7));
    send_word(mk(3'd6, VAL_POS_MAX, 0, 0, 0, 0, 0, 1));
    send_word(mk(CMD_RSVD_HI, VAL_MOST_NEG, 0, 0, 0, 0, 0, 5'd31));
    send_word(mk(CMD_ALIGN, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int k = 0; k < PHASE_ITEMS; k++) send_word(rand_word());
      // hold the sender until the output side has caught up
      wait_drained();
    end
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.bytes_due.size() != 0) begin
      $display("%0t: %0d words still expected at end", $time, sb.bytes_due.size());
      sb.fail_count++;
    end
    $display("words in: rect %0d matrix %0d edge %0d raw %0d align %0d unused codes %0d",
             sb.cmd_seen[CMD_RECT], sb.cmd_seen[CMD_MATRIX], sb.cmd_seen[CMD_EDGE],
             sb.cmd_seen[CMD_RAW], sb.cmd_seen[CMD_ALIGN],
             sb.cmd_seen[5] + sb.cmd_seen[6] + sb.cmd_seen[7]);
    $display("bytes out checked: %0d, range errors among them: %0d, mismatches: %0d",
             sb.bytes_checked, sb.range_errors, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
